FILE: sv/hsl2rgb_pkg.sv
`default_nettype none

package hsl2rgb_pkg;

    localparam int HUE_W = 12;
    localparam int IN_W = 13;
    localparam int CH_W = 8;
    localparam int WEIGHT_W = 10;
    localparam int WEIGHT_SHIFT = 9;
    localparam int SCALE_SHIFT = 8;

    localparam logic [HUE_W-1:0] HUE_TURN = 12'd3072;
    localparam logic [HUE_W-1:0] HUE_THIRD = 12'd1024;
    localparam logic [HUE_W-1:0] HUE_TWO_THIRDS = 12'd2048;
    localparam logic [HUE_W-1:0] HUE_SIXTH = 12'd512;
    localparam logic [HUE_W-1:0] HUE_HALF = 12'd1536;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 10'd512;

    typedef struct packed {
        logic [WEIGHT_W-1:0] blue;
        logic [WEIGHT_W-1:0] green;
        logic [WEIGHT_W-1:0] red;
    } weights_t;

    typedef struct packed {
        logic [CH_W-1:0] opacity;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgba_t;

endpackage

`default_nettype wire

FILE: sv/hsl2rgb_front.sv
`default_nettype none

module hsl2rgb_front #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire logic [hsl2rgb_pkg::HUE_W-1:0]      hue,
    input  wire logic [hsl2rgb_pkg::IN_W-1:0]       saturation,
    input  wire logic [hsl2rgb_pkg::IN_W-1:0]       lightness,
    input  wire logic [hsl2rgb_pkg::IN_W-1:0]       alpha,
    output logic                                    out_valid,
    output logic [FRAC_BITS:0]                      sat,
    output logic [FRAC_BITS:0]                      light,
    output hsl2rgb_pkg::weights_t                   weights,
    output logic [hsl2rgb_pkg::CH_W-1:0]            opacity
);

    localparam int CMP_W = (hsl2rgb_pkg::IN_W > FRAC_BITS + 1) ?
                           hsl2rgb_pkg::IN_W : FRAC_BITS + 1;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam int HW = hsl2rgb_pkg::HUE_W;
    localparam int WW = hsl2rgb_pkg::WEIGHT_W;
    localparam int AW = FRAC_BITS + hsl2rgb_pkg::CH_W + 1;

    function automatic logic [FRAC_BITS:0] sat_one(input logic [hsl2rgb_pkg::IN_W-1:0] x);
        logic [CMP_W-1:0] x_ext;
        x_ext = CMP_W'(x);
        if (x_ext > CMP_W'(ONE))
            return ONE;
        return x_ext[FRAC_BITS:0];
    endfunction

    function automatic logic [HW-1:0] hue_offset(input logic [HW-1:0] h,
                                                  input logic [HW-1:0] off);
        logic [HW:0] sum;
        sum = {1'b0, h} + {1'b0, off};
        if (sum >= {1'b0, hsl2rgb_pkg::HUE_TURN})
            sum = sum - {1'b0, hsl2rgb_pkg::HUE_TURN};
        return sum[HW-1:0];
    endfunction

    function automatic logic [WW-1:0] hue_weight(input logic [HW-1:0] k);
        logic [HW-1:0] diff;
        diff = hsl2rgb_pkg::HUE_TWO_THIRDS - k;
        if (k < hsl2rgb_pkg::HUE_SIXTH)
            return k[WW-1:0];
        else if (k < hsl2rgb_pkg::HUE_HALF)
            return hsl2rgb_pkg::WEIGHT_FULL;
        else if (k < hsl2rgb_pkg::HUE_TWO_THIRDS)
            return diff[WW-1:0];
        return '0;
    endfunction

    logic [HW-1:0]          hue_wrap;
    logic [FRAC_BITS:0]     alpha_sat;
    logic [AW-1:0]          alpha_scaled;
    hsl2rgb_pkg::weights_t  weights_next;

    assign hue_wrap = (hue >= hsl2rgb_pkg::HUE_TURN) ? hue - hsl2rgb_pkg::HUE_TURN : hue;
    assign alpha_sat = sat_one(alpha);
    assign alpha_scaled = {alpha_sat, {hsl2rgb_pkg::CH_W{1'b0}}} - AW'(alpha_sat);

    always_comb
    begin
        weights_next.red = hue_weight(hue_offset(hue_wrap, hsl2rgb_pkg::HUE_THIRD));
        weights_next.green = hue_weight(hue_wrap);
        weights_next.blue = hue_weight(hue_offset(hue_wrap, hsl2rgb_pkg::HUE_TWO_THIRDS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat <= sat_one(saturation);
            light <= sat_one(lightness);
            weights <= weights_next;
            opacity <= alpha_scaled[FRAC_BITS+hsl2rgb_pkg::CH_W-1:FRAC_BITS];
        end
    end

endmodule

`default_nettype wire

FILE: sv/hsl2rgb_mix.sv
`default_nettype none

module hsl2rgb_mix #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [FRAC_BITS:0]     sat,
    input  wire logic [FRAC_BITS:0]     light,
    input  wire hsl2rgb_pkg::weights_t  weights_in,
    output logic                        out_valid,
    output logic [2*FRAC_BITS:0]        m1,
    output logic [2*FRAC_BITS:0]        delta,
    output hsl2rgb_pkg::weights_t       weights_out
);

    localparam int W2 = 2 * FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

    logic                   valid_a_reg;
    logic [2*FRAC_BITS:0]   ls_a_reg;
    logic [FRAC_BITS:0]     light_a_reg;
    logic [FRAC_BITS:0]     sat_a_reg;
    logic                   low_a_reg;
    hsl2rgb_pkg::weights_t  weights_a_reg;

    logic [W2-1:0]          ls_full;
    logic [W2-1:0]          l_sh;
    logic [W2-1:0]          s_sh;
    logic [W2-1:0]          ls_ext;
    logic [W2-1:0]          m1_next;
    logic [W2-1:0]          delta_next;

    assign ls_full = light * sat;
    assign l_sh = W2'(light_a_reg) << FRAC_BITS;
    assign s_sh = W2'(sat_a_reg) << FRAC_BITS;
    assign ls_ext = W2'(ls_a_reg);

    always_comb
    begin
        if (low_a_reg)
        begin
            m1_next = l_sh - ls_ext;
            delta_next = ls_ext << 1;
        end
        else
        begin
            m1_next = l_sh - s_sh + ls_ext;
            delta_next = (s_sh << 1) - (ls_ext << 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            out_valid <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ls_a_reg <= ls_full[2*FRAC_BITS:0];
            light_a_reg <= light;
            sat_a_reg <= sat;
            low_a_reg <= (light <= HALF);
            weights_a_reg <= weights_in;
            m1 <= m1_next[2*FRAC_BITS:0];
            delta <= delta_next[2*FRAC_BITS:0];
            weights_out <= weights_a_reg;
        end
    end

endmodule

`default_nettype wire

FILE: sv/hsl2rgb_ramp.sv
`default_nettype none

module hsl2rgb_ramp #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                                   clk,
    input  wire logic                                   en,
    input  wire logic [2*FRAC_BITS:0]                   m1,
    input  wire logic [2*FRAC_BITS:0]                   delta,
    input  wire logic [hsl2rgb_pkg::WEIGHT_W-1:0]       weight,
    output logic [hsl2rgb_pkg::CH_W-1:0]                channel
);

    localparam int VW = 2 * FRAC_BITS + hsl2rgb_pkg::WEIGHT_SHIFT + 1;
    localparam int PW = 2 * FRAC_BITS + hsl2rgb_pkg::WEIGHT_W + 1;
    localparam int SW = VW + hsl2rgb_pkg::SCALE_SHIFT;
    localparam int OUT_LSB = 2 * FRAC_BITS + hsl2rgb_pkg::WEIGHT_SHIFT;

    logic [PW-1:0]          prod_full;
    logic [VW-1:0]          prod_reg;
    logic [2*FRAC_BITS:0]   m1_reg;
    logic [VW-1:0]          level_next;
    logic [VW-1:0]          level_reg;
    logic [SW-1:0]          scaled;

    assign prod_full = delta * weight;
    assign level_next = (VW'(m1_reg) << hsl2rgb_pkg::WEIGHT_SHIFT) + prod_reg;
    assign scaled = {level_reg, {hsl2rgb_pkg::SCALE_SHIFT{1'b0}}} - SW'(level_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_full[VW-1:0];
            m1_reg <= m1;
            level_reg <= level_next;
            channel <= scaled[OUT_LSB+hsl2rgb_pkg::CH_W-1:OUT_LSB];
        end
    end

endmodule

`default_nettype wire

FILE: sv/hsl2rgb_skid.sv
`default_nettype none

module hsl2rgb_skid (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire hsl2rgb_pkg::rgba_t in_data,
    output logic                    advance,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hsl2rgb_pkg::rgba_t      out_data
);

    logic                   full_reg;
    logic                   full_next;
    hsl2rgb_pkg::rgba_t     hold_reg;

    assign advance = !full_reg;
    assign out_valid = full_reg || in_valid;
    assign out_data = full_reg ? hold_reg : in_data;

    always_comb
    begin
        full_next = full_reg;
        if (full_reg && out_ready)
            full_next = 1'b0;
        else if (!full_reg && in_valid && !out_ready)
            full_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!full_reg)
        begin
            hold_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/hsl_to_rgb_converter.sv
// Converts one HSL colour with alpha into 8-bit RGBA per clock by the CSS3 rule while the
// output is not stalled. Hue is in units of 1/3072 turn and wraps; saturation, lightness and
// alpha are Q1.FRAC_BITS values that saturate at one. The datapath is a six-stage pipeline
// (input conditioning, lightness times saturation product, m1 and ramp slope, one hue-weight
// multiplier per channel, ramp sum, scale by 255), and a new colour can be taken every clock
// while the output is not stalled. A skid register behind the last stage holds one result
// while the output is stalled; s_axis_tready drops the cycle after such a stall and returns
// once that result has been taken.
`default_nettype none

module hsl_to_rgb_converter #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    // hue[11:0], saturation[24:12], lightness[37:25], alpha[50:38], zero padding above.
    input  wire logic [55:0]    s_axis_tdata,
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], opacity[31:24].
    output logic [31:0]         m_axis_tdata
);

    localparam int RAMP_STAGES = 3;

    logic                                   en;
    logic                                   front_valid;
    logic [FRAC_BITS:0]                     front_sat;
    logic [FRAC_BITS:0]                     front_light;
    hsl2rgb_pkg::weights_t                  front_weights;
    logic [hsl2rgb_pkg::CH_W-1:0]           front_opacity;
    logic                                   mix_valid;
    logic [2*FRAC_BITS:0]                   mix_m1;
    logic [2*FRAC_BITS:0]                   mix_delta;
    hsl2rgb_pkg::weights_t                  mix_weights;
    logic [RAMP_STAGES-1:0]                 ramp_valid_reg;
    logic [hsl2rgb_pkg::CH_W-1:0]           opacity_reg [RAMP_STAGES+2];
    hsl2rgb_pkg::rgba_t                     pixel;
    hsl2rgb_pkg::rgba_t                     out_pixel;

    hsl2rgb_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_valid(s_axis_tvalid),
        .hue(s_axis_tdata[11:0]),
        .saturation(s_axis_tdata[24:12]),
        .lightness(s_axis_tdata[37:25]),
        .alpha(s_axis_tdata[50:38]),
        .out_valid(front_valid),
        .sat(front_sat),
        .light(front_light),
        .weights(front_weights),
        .opacity(front_opacity)
    );

    hsl2rgb_mix #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mix (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .in_valid(front_valid),
        .sat(front_sat),
        .light(front_light),
        .weights_in(front_weights),
        .out_valid(mix_valid),
        .m1(mix_m1),
        .delta(mix_delta),
        .weights_out(mix_weights)
    );

    hsl2rgb_ramp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ramp_red (
        .clk(clk),
        .en(en),
        .m1(mix_m1),
        .delta(mix_delta),
        .weight(mix_weights.red),
        .channel(pixel.red)
    );

    hsl2rgb_ramp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ramp_green (
        .clk(clk),
        .en(en),
        .m1(mix_m1),
        .delta(mix_delta),
        .weight(mix_weights.green),
        .channel(pixel.green)
    );

    hsl2rgb_ramp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ramp_blue (
        .clk(clk),
        .en(en),
        .m1(mix_m1),
        .delta(mix_delta),
        .weight(mix_weights.blue),
        .channel(pixel.blue)
    );

    assign pixel.opacity = opacity_reg[RAMP_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_valid_reg <= '0;
        end
        else if (en)
        begin
            ramp_valid_reg <= {ramp_valid_reg[RAMP_STAGES-2:0], mix_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            opacity_reg[0] <= front_opacity;
            for (int i = 1; i < RAMP_STAGES + 2; i++)
            begin
                opacity_reg[i] <= opacity_reg[i-1];
            end
        end
    end

    hsl2rgb_skid u_skid (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(ramp_valid_reg[RAMP_STAGES-1]),
        .in_data(pixel),
        .advance(en),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data(out_pixel)
    );

    assign s_axis_tready = en;
    assign m_axis_tdata = out_pixel;

endmodule

`default_nettype wire

FILE: sv/hsl2rgb_checker.sv
`default_nettype none

module hsl2rgb_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_axis_tvalid,
    input  wire logic           s_axis_tready,
    input  wire logic           m_axis_tvalid,
    input  wire logic           m_axis_tready,
    input  wire logic [31:0]    m_axis_tdata
);

    // A stalled result transaction keeps its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The input side is only held back while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input blocked with no result pending");

    // The input side is only held back after an output stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input blocked without an output stall");

    // Once the held result is taken, the input side opens again.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready && m_axis_tvalid && m_axis_tready |=> s_axis_tready)
        else $error("input stayed blocked after the held result was taken");

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

`default_nettype wire

FILE: tb/hsl_to_rgb_converter_checker.sv
`timescale 1ns / 100ps

module hsl_to_rgb_converter_checker
    import hsl2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [55:0] s_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_data,
    output int               mismatches,
    output int               outstanding
);

    localparam longint TURN = HUE_TURN;
    localparam longint THIRD = HUE_THIRD;
    localparam longint SIXTH = HUE_SIXTH;
    localparam longint HALF = HUE_HALF;
    localparam longint TWO_THIRDS = HUE_TWO_THIRDS;
    localparam longint CH_MAX = 255;
    localparam int LEVEL_SHIFT = 2 * FRAC_BITS + $clog2(SIXTH);

    rgba_t expected_rgba[$];
    string channel_names[4] = '{"red", "green", "blue", "opacity"};

    initial mismatches = 0;

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic longint clip_to_one(input longint x);
        longint one;
        one = longint'(1) << FRAC_BITS;
        return (x > one) ? one : x;
    endfunction

    function automatic logic [CH_W-1:0] channel_level(input longint m1, input longint m2,
                                                      input longint pos);
        longint v;
        longint d;
        longint full;
        d = m2 - m1;
        full = longint'(1) << LEVEL_SHIFT;
        if (pos < SIXTH)
            v = m1 * SIXTH + d * pos;
        else if (pos < HALF)
            v = m2 * SIXTH;
        else if (pos < TWO_THIRDS)
            v = m1 * SIXTH + d * (TWO_THIRDS - pos);
        else
            v = m1 * SIXTH;
        if (v < 0)
            v = 0;
        if (v > full)
            v = full;
        return CH_W'((v * CH_MAX) >>> LEVEL_SHIFT);
    endfunction

    function automatic rgba_t predict_rgba(input logic [55:0] word);
        longint one;
        longint hue;
        longint sat;
        longint lit;
        longint alp;
        longint m1;
        longint m2;
        rgba_t colour;
        one = longint'(1) << FRAC_BITS;
        hue = longint'(word[HUE_W-1:0]) % TURN;
        sat = clip_to_one(longint'(word[HUE_W +: IN_W]));
        lit = clip_to_one(longint'(word[HUE_W + IN_W +: IN_W]));
        alp = clip_to_one(longint'(word[HUE_W + 2 * IN_W +: IN_W]));
        if (2 * lit <= one)
            m2 = lit * (sat + one);
        else
            m2 = (lit + sat) * one - lit * sat;
        m1 = 2 * lit * one - m2;
        colour.red = channel_level(m1, m2, (hue + THIRD) % TURN);
        colour.green = channel_level(m1, m2, hue);
        colour.blue = channel_level(m1, m2, (hue + TURN - THIRD) % TURN);
        colour.opacity = CH_W'((alp * CH_MAX) >>> FRAC_BITS);
        return colour;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rgba_t want;
        if (!rst_n)
        begin
            outstanding <= 0;
        end
        else
        begin
            if (m_valid && m_ready)
            begin
                if (expected_rgba.size() == 0)
                begin
                    report_error($sformatf("result %08h with no colour outstanding", m_data));
                end
                else
                begin
                    want = expected_rgba.pop_front();
                    for (int i = 0; i < 4; i++)
                    begin
                        if (want[i * CH_W +: CH_W] !== m_data[i * CH_W +: CH_W])
                            report_error($sformatf("%s mismatch: expected %0d, got %0d",
                                                   channel_names[i], want[i * CH_W +: CH_W],
                                                   m_data[i * CH_W +: CH_W]));
                    end
                end
            end
            if (s_valid && s_ready)
                expected_rgba.push_back(predict_rgba(s_data));
            outstanding <= outstanding + int'(s_valid && s_ready)
                           - int'(m_valid && m_ready && expected_rgba.size() >= 0
                                  && outstanding > 0);
        end
    end

endmodule

FILE: tb/hsl_to_rgb_converter_test.sv
`timescale 1ns / 100ps

module hsl_to_rgb_converter_test;

    import hsl2rgb_pkg::*;

    localparam int FRAC = 12;
    localparam int WAIT_MAX = 12;
    localparam int RANDOM_ITEMS = 1500;
    localparam int PHASE_ITEMS = 250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;

    localparam int MODE_BOTH_IDLE = 0;
    localparam int MODE_NO_IDLE = 1;
    localparam int MODE_SINK_STALLS = 2;
    localparam int MODE_SOURCE_GAPS = 3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    // hue[11:0], saturation[24:12], lightness[37:25], alpha[50:38], zero padding above.
    logic [55:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // red[7:0], green[15:8], blue[23:16], opacity[31:24].
    wire  [31:0] m_axis_tdata;

    int mismatches;
    int outstanding;
    int idle_mode = MODE_BOTH_IDLE;
    int quiet_cycles = 0;

    always #6 clk = ~clk;

    hsl_to_rgb_converter #(
        .FRAC_BITS(FRAC)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    hsl_to_rgb_converter_checker #(
        .FRAC_BITS(FRAC)
    ) rgba_monitor (
        .clk(clk),
        .rst_n(rst_n),
        .s_valid(s_axis_tvalid),
        .s_ready(s_axis_tready),
        .s_data(s_axis_tdata),
        .m_valid(m_axis_tvalid),
        .m_ready(m_axis_tready),
        .m_data(m_axis_tdata),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    function automatic logic [55:0] pack_colour(input logic [HUE_W-1:0] hue,
                                                input logic [IN_W-1:0] sat,
                                                input logic [IN_W-1:0] lit,
                                                input logic [IN_W-1:0] alp);
        return {5'b0, alp, lit, sat, hue};
    endfunction

    function automatic logic [55:0] random_colour();
        int kind;
        logic [HUE_W-1:0] hue;
        logic [IN_W-1:0] sat;
        logic [IN_W-1:0] lit;
        logic [IN_W-1:0] alp;
        kind = $urandom_range(0, 9);
        hue = HUE_W'($urandom_range(0, 3071));
        sat = IN_W'($urandom_range(0, 4096));
        lit = IN_W'($urandom_range(0, 4096));
        alp = IN_W'($urandom_range(0, 4096));
        if (kind == 0)
            hue = HUE_W'(HUE_SIXTH * $urandom_range(0, 6) + $urandom_range(0, 2) - 1);
        else if (kind == 1)
            lit = IN_W'((1 << (FRAC - 1)) + $urandom_range(0, 2) - 1);
        else if (kind >= 7)
        begin
            hue = HUE_W'($urandom);
            sat = IN_W'($urandom);
            lit = IN_W'($urandom);
            alp = IN_W'($urandom);
        end
        return pack_colour(hue, sat, lit, alp);
    endfunction

    task automatic send_colour(input logic [55:0] word);
        int gap;
        gap = (idle_mode == MODE_BOTH_IDLE || idle_mode == MODE_SOURCE_GAPS)
              ? $urandom_range(0, WAIT_MAX) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_colour(pack_colour(0, 0, 0, 0));
        send_colour(pack_colour(0, 4096, 4096, 4096));
        send_colour(pack_colour(0, 4096, 2048, 4096));
        send_colour(pack_colour(0, 4096, 2049, 4095));
        send_colour(pack_colour(1024, 4096, 2048, 2048));
        send_colour(pack_colour(2048, 4096, 2048, 1));
        send_colour(pack_colour(511, 4096, 2048, 4096));
        send_colour(pack_colour(512, 4096, 2048, 4096));
        send_colour(pack_colour(1535, 4096, 2048, 4096));
        send_colour(pack_colour(1536, 4096, 2048, 4096));
        send_colour(pack_colour(2047, 4096, 2048, 4096));
        send_colour(pack_colour(3071, 4096, 2048, 4096));
        send_colour(pack_colour(3072, 4096, 2048, 4096));
        send_colour(pack_colour(4095, 8191, 2048, 8191));
        send_colour(pack_colour(1000, 8191, 8191, 8191));
        send_colour(pack_colour(300, 2000, 1000, 0));
        send_colour(pack_colour(2500, 0, 3000, 4097));
        send_colour(pack_colour(700, 4096, 2047, 4096));
        send_colour(pack_colour(1800, 1, 4095, 2));
        send_colour(pack_colour(2900, 3000, 0, 4096));
        send_colour(pack_colour(100, 4096, 1, 4096));
        wait_for_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_mode = (n / PHASE_ITEMS) % 4;
            if (n == RANDOM_ITEMS / 2)
                wait_for_drain();
            send_colour(random_colour());
        end
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = (idle_mode == MODE_NO_IDLE || idle_mode == MODE_SOURCE_GAPS)
                    ? 0 : $urandom_range(0, WAIT_MAX);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // The watchdog counts cycles in which no transaction completes on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule
